// ===== hdl/dtt_pkg.sv =====
// shared types and constants of the deadline timer table
// depends on nothing; used by dtt_cell, dtt_ctrl and deadline_timer_table
package dtt_pkg;

  // slot index width inside the cell chain, enough for the largest table
  localparam int SLOT_W = 6;
  localparam logic [63:0] ONE_HOUR_MS = 64'd3600000;
  localparam int MAX_EMIT = 16;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_CANCEL  = 3'd1,
    CMD_REFRESH = 3'd2,
    CMD_RESET   = 3'd3,
    CMD_POLL    = 3'd4,
    CMD_QUERY   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOACT = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_CALC,
    S_EVAL
  } state_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ADD,
    WR_DISARM,
    WR_DL,
    WR_IVDL,
    WR_MARK
  } wr_op_e;

  // broadcast write from the controller to all cells
  typedef struct packed {
    wr_op_e            op;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       dl;
    logic [31:0]       ival;
    logic              rec;
    logic [31:0]       tag;
  } wr_t;

  // earliest eligible entry seen so far
  typedef struct packed {
    logic              found;
    logic [63:0]       dl;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       tag;
    logic [31:0]       ival;
    logic              rec;
  } best_t;

  // addressed entry picked up along the chain
  typedef struct packed {
    logic        armed;
    logic [63:0] dl;
    logic [31:0] ival;
  } tgt_t;

  // record handed from cell to cell
  typedef struct packed {
    logic              use_due;
    logic              excl_en;
    logic [SLOT_W-1:0] excl;
    logic [SLOT_W-1:0] tslot;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              any_armed;
    logic              any_other;
    logic              stay;
    logic [SLOT_W:0]   due_cnt;
    best_t             best;
    tgt_t              tgt;
  } scan_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [63:0] wait_ms;
    logic        fn;
    logic        any;
    logic        last;
  } res_t;

endpackage

// ===== hdl/dtt_cell.sv =====
// one timer slot of the chain: holds its entry and folds it into the passing record
// depends on dtt_pkg
module dtt_cell #(
  parameter int IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dtt_pkg::wr_t   wr_i,
  input  dtt_pkg::scan_t scan_i,
  output dtt_pkg::scan_t scan_o
);

  localparam logic [dtt_pkg::SLOT_W-1:0] MySlot = (dtt_pkg::SLOT_W)'(IDX);

  logic        armed_q, due_q;
  logic [63:0] dl_q;
  logic [31:0] ival_q, tag_q;
  logic        rec_q;
  logic        hit, elig;
  dtt_pkg::scan_t scan_d, scan_q;

  assign hit = (wr_i.slot == MySlot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      due_q   <= 1'b0;
    end else begin
      case (wr_i.op)
        dtt_pkg::WR_ADD: if (hit) armed_q <= 1'b1;
        dtt_pkg::WR_DISARM: if (hit) begin
          armed_q <= 1'b0;
          due_q   <= 1'b0;
        end
        dtt_pkg::WR_DL: if (hit) due_q <= 1'b0;
        dtt_pkg::WR_MARK: due_q <= armed_q && (wr_i.rec || dl_q <= wr_i.dl);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (wr_i.op)
      dtt_pkg::WR_ADD: if (hit) begin
        dl_q   <= wr_i.dl;
        ival_q <= wr_i.ival;
        rec_q  <= wr_i.rec;
        tag_q  <= wr_i.tag;
      end
      dtt_pkg::WR_DL: if (hit) dl_q <= wr_i.dl;
      dtt_pkg::WR_IVDL: if (hit) begin
        dl_q   <= wr_i.dl;
        ival_q <= wr_i.ival;
      end
      default: ;
    endcase
  end

  // strict compare: on equal deadlines the lower slot seen earlier stays
  always_comb begin
    scan_d = scan_i;
    elig = scan_i.use_due ? due_q
                          : (armed_q && !(scan_i.excl_en && scan_i.excl == MySlot));
    if (elig && (!scan_i.best.found || dl_q < scan_i.best.dl)) begin
      scan_d.best.found = 1'b1;
      scan_d.best.dl    = dl_q;
      scan_d.best.slot  = MySlot;
      scan_d.best.tag   = tag_q;
      scan_d.best.ival  = ival_q;
      scan_d.best.rec   = rec_q;
    end
    if (!scan_i.free_found && !armed_q) begin
      scan_d.free_found = 1'b1;
      scan_d.free_slot  = MySlot;
    end
    scan_d.any_armed = scan_i.any_armed | armed_q;
    scan_d.any_other = scan_i.any_other | (armed_q && scan_i.tslot != MySlot);
    scan_d.stay      = scan_i.stay | (armed_q && (!due_q || rec_q));
    scan_d.due_cnt   = scan_i.due_cnt + {{dtt_pkg::SLOT_W{1'b0}}, due_q};
    if (scan_i.tslot == MySlot) begin
      scan_d.tgt.armed = armed_q;
      scan_d.tgt.dl    = dl_q;
      scan_d.tgt.ival  = ival_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

endmodule

// ===== hdl/dtt_ctrl.sv =====
// command sequencer of the timer table: launches chain passes, evaluates, writes back
// depends on dtt_pkg
module dtt_ctrl #(
  parameter int NUM_TIMERS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     cmd_i,
  input  logic [63:0]    now_i,
  input  logic [3:0]     sid_i,
  input  logic [31:0]    per_i,
  input  logic           rep_i,
  input  logic           rnow_i,
  input  logic [31:0]    utag_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output dtt_pkg::res_t  res_o,
  output dtt_pkg::wr_t   wr_o,
  output dtt_pkg::scan_t scan_o,
  input  dtt_pkg::scan_t scan_i
);

  localparam int CW = $clog2(NUM_TIMERS);
  localparam int SW = dtt_pkg::SLOT_W;

  dtt_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    cmd_q, cmd_d;
  logic [63:0]   now_q, now_d;
  logic [3:0]    sid_q, sid_d;
  logic [31:0]   per_q, per_d, utag_q, utag_d;
  logic          rep_q, rep_d, rnow_q, rnow_d;
  logic          due_mode_q, due_mode_d, first_q, first_d;
  logic [4:0]    n_q, n_d, ntot_q, ntot_d;
  logic          anyfin_q, anyfin_d, notified_q, notified_d, jump_q, jump_d;
  logic [63:0]   last_poll_q, last_poll_d, base_q, base_d, cdl_q, cdl_d;
  logic [31:0]   addend_q, addend_d;
  dtt_pkg::res_t res_q, res_d;
  logic          m_valid_q, m_valid_d;

  logic          out_free, valid_c, front, anyfin_c, last_c;
  logic [SW-1:0] my_slot;
  logic [63:0]   wait_c;
  logic [64:0]   sum_c;
  logic [4:0]    ntot_c;

  assign out_free = !m_valid_q || out_ready_i;
  assign valid_c  = ({{(SW-3){1'b0}}, sid_q} < (SW+1)'(NUM_TIMERS));
  assign my_slot  = (cmd_q == dtt_pkg::CMD_ADD) ? scan_i.free_slot : SW'(sid_q);
  assign front    = !scan_i.best.found || cdl_q < scan_i.best.dl ||
                    (cdl_q == scan_i.best.dl && my_slot < scan_i.best.slot);
  assign wait_c   = !scan_i.best.found ? {64{1'b1}} :
                    (now_q >= scan_i.best.dl) ? 64'd0 : scan_i.best.dl - now_q;
  assign sum_c    = {1'b0, base_q} + {33'd0, addend_q};
  assign ntot_c   = !first_q ? ntot_q :
                    (scan_i.due_cnt > (SW+1)'(dtt_pkg::MAX_EMIT)) ? 5'(dtt_pkg::MAX_EMIT)
                                                                  : scan_i.due_cnt[4:0];
  assign anyfin_c = !first_q ? anyfin_q :
                    (scan_i.stay || scan_i.due_cnt > (SW+1)'(dtt_pkg::MAX_EMIT));
  assign last_c   = ((n_q + 5'd1) == ntot_c);

  // record entering the head of the chain
  always_comb begin
    scan_o         = '0;
    scan_o.use_due = due_mode_q;
    scan_o.excl_en = (cmd_q == dtt_pkg::CMD_RESET);
    scan_o.excl    = SW'(sid_q);
    scan_o.tslot   = SW'(sid_q);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    now_d       = now_q;
    sid_d       = sid_q;
    per_d       = per_q;
    utag_d      = utag_q;
    rep_d       = rep_q;
    rnow_d      = rnow_q;
    due_mode_d  = due_mode_q;
    first_d     = first_q;
    n_d         = n_q;
    ntot_d      = ntot_q;
    anyfin_d    = anyfin_q;
    notified_d  = notified_q;
    jump_d      = jump_q;
    last_poll_d = last_poll_q;
    base_d      = base_q;
    addend_d    = addend_q;
    cdl_d       = cdl_q;
    res_d       = res_q;
    m_valid_d   = m_valid_q && !out_ready_i;
    wr_o        = '0;
    wr_o.op     = dtt_pkg::WR_NONE;
    in_ready_o  = (state_q == dtt_pkg::S_IDLE);

    case (state_q)
      dtt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          now_d   = now_i;
          sid_d   = sid_i;
          per_d   = per_i;
          rep_d   = rep_i;
          rnow_d  = rnow_i;
          utag_d  = utag_i;
          cnt_d   = '0;
          state_d = dtt_pkg::S_SCAN;
        end
      end
      dtt_pkg::S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(NUM_TIMERS - 1)) begin
          cnt_d   = '0;
          state_d = dtt_pkg::S_PREP;
        end
      end
      dtt_pkg::S_PREP: begin
        base_d   = now_q;
        addend_d = per_q;
        if (cmd_q == dtt_pkg::CMD_RESET && !rnow_q)
          base_d = scan_i.tgt.dl - {32'd0, scan_i.tgt.ival};
        if (cmd_q == dtt_pkg::CMD_REFRESH) addend_d = scan_i.tgt.ival;
        if (cmd_q == dtt_pkg::CMD_POLL) addend_d = scan_i.best.ival;
        jump_d  = (last_poll_q > now_q) && ((last_poll_q - now_q) > dtt_pkg::ONE_HOUR_MS);
        state_d = dtt_pkg::S_CALC;
      end
      dtt_pkg::S_CALC: begin
        cdl_d   = sum_c[64] ? {64{1'b1}} : sum_c[63:0];
        state_d = dtt_pkg::S_EVAL;
      end
      dtt_pkg::S_EVAL: begin
        if (out_free) begin
          res_d        = '0;
          res_d.status = dtt_pkg::ST_OK;
          res_d.any    = scan_i.any_armed;
          res_d.last   = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = dtt_pkg::S_IDLE;
          case (cmd_q)
            dtt_pkg::CMD_ADD: begin
              if (!scan_i.free_found) begin
                res_d.status = dtt_pkg::ST_FULL;
              end else begin
                wr_o.op   = dtt_pkg::WR_ADD;
                wr_o.slot = scan_i.free_slot;
                wr_o.dl   = cdl_q;
                wr_o.ival = per_q;
                wr_o.rec  = rep_q;
                wr_o.tag  = utag_q;
                res_d.slot = scan_i.free_slot[3:0];
                res_d.any  = 1'b1;
                if (front && !notified_q) begin
                  res_d.fn   = 1'b1;
                  notified_d = 1'b1;
                end
              end
            end
            dtt_pkg::CMD_CANCEL: begin
              if (valid_c && scan_i.tgt.armed) begin
                wr_o.op   = dtt_pkg::WR_DISARM;
                wr_o.slot = SW'(sid_q);
                res_d.any = scan_i.any_other;
              end else begin
                res_d.status = dtt_pkg::ST_NOACT;
              end
            end
            dtt_pkg::CMD_REFRESH: begin
              if (valid_c && scan_i.tgt.armed) begin
                wr_o.op   = dtt_pkg::WR_DL;
                wr_o.slot = SW'(sid_q);
                wr_o.dl   = cdl_q;
              end else begin
                res_d.status = dtt_pkg::ST_NOACT;
              end
            end
            dtt_pkg::CMD_RESET: begin
              if (valid_c && per_q == scan_i.tgt.ival && !rnow_q) begin
                res_d.status = dtt_pkg::ST_OK;
              end else if (!valid_c || !scan_i.tgt.armed) begin
                res_d.status = dtt_pkg::ST_NOACT;
              end else begin
                wr_o.op   = dtt_pkg::WR_IVDL;
                wr_o.slot = SW'(sid_q);
                wr_o.dl   = cdl_q;
                wr_o.ival = per_q;
                if (front && !notified_q) begin
                  res_d.fn   = 1'b1;
                  notified_d = 1'b1;
                end
              end
            end
            dtt_pkg::CMD_QUERY: begin
              notified_d    = 1'b0;
              res_d.wait_ms = wait_c;
            end
            dtt_pkg::CMD_POLL: begin
              if (!due_mode_q) begin
                if (!scan_i.any_armed) begin
                  res_d.status = dtt_pkg::ST_NONE;
                end else begin
                  // latch the due set, then run passes over it
                  m_valid_d   = m_valid_q && !out_ready_i;
                  wr_o.op     = dtt_pkg::WR_MARK;
                  wr_o.dl     = now_q;
                  wr_o.rec    = jump_q;
                  last_poll_d = now_q;
                  due_mode_d  = 1'b1;
                  first_d     = 1'b1;
                  n_d         = '0;
                  state_d     = dtt_pkg::S_SCAN;
                end
              end else begin
                first_d  = 1'b0;
                ntot_d   = ntot_c;
                anyfin_d = anyfin_c;
                res_d.any = anyfin_c;
                if (ntot_c == 5'd0) begin
                  res_d.status = dtt_pkg::ST_NONE;
                  due_mode_d   = 1'b0;
                end else begin
                  res_d.slot = scan_i.best.slot[3:0];
                  res_d.tag  = scan_i.best.tag;
                  res_d.last = last_c;
                  wr_o.slot  = scan_i.best.slot;
                  wr_o.dl    = cdl_q;
                  wr_o.op    = scan_i.best.rec ? dtt_pkg::WR_DL : dtt_pkg::WR_DISARM;
                  n_d        = n_q + 5'd1;
                  if (last_c) begin
                    due_mode_d = 1'b0;
                  end else begin
                    state_d = dtt_pkg::S_SCAN;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = dtt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtt_pkg::S_IDLE;
      cnt_q       <= '0;
      due_mode_q  <= 1'b0;
      first_q     <= 1'b0;
      n_q         <= '0;
      ntot_q      <= '0;
      anyfin_q    <= 1'b0;
      notified_q  <= 1'b0;
      last_poll_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      due_mode_q  <= due_mode_d;
      first_q     <= first_d;
      n_q         <= n_d;
      ntot_q      <= ntot_d;
      anyfin_q    <= anyfin_d;
      notified_q  <= notified_d;
      last_poll_q <= last_poll_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    now_q    <= now_d;
    sid_q    <= sid_d;
    per_q    <= per_d;
    utag_q   <= utag_d;
    rep_q    <= rep_d;
    rnow_q   <= rnow_d;
    jump_q   <= jump_d;
    base_q   <= base_d;
    addend_q <= addend_d;
    cdl_q    <= cdl_d;
    res_q    <= res_d;
  end

  assign out_valid_o = m_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/deadline_timer_table.sv =====
// deadline timer table top level: sequencer plus a chain of NUM_TIMERS slot cells
// depends on dtt_pkg, dtt_ctrl, dtt_cell
// flow: a request makes one pass of the record down the chain, then the sequencer
//   prepares, adds and evaluates; the answer waits in evaluation while the output is held
// busy: no new request is taken until the answer to the last one is issued; a poll
//   spends one extra pass to latch the due set and one pass per expired timer that it
//   reports, at most MAX_EMIT per poll
// reset: asynchronous, all timers disarmed, notify flag and last poll time cleared
module deadline_timer_table #(
  parameter int NUM_TIMERS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // now_time[63:0], slot_id[67:64], period[99:68], repeat_req[100],
  // restart_now[101], user_tag[133:102], zero fill up to bit 135
  input  logic [135:0] s_axis_tdata_i,
  // cmd[2:0]
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_slot[3:0], out_tag[35:4], wait_time[99:36], front_notify[100],
  // any_active[101], zero fill up to bit 103
  output logic [103:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  // broadcast writes from the sequencer to every cell
  dtt_pkg::wr_t   wr;
  dtt_pkg::res_t  res;
  // record taps along the chain: head from the sequencer, tail back to it
  dtt_pkg::scan_t chain_w [NUM_TIMERS+1];

  dtt_ctrl #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .now_i       (s_axis_tdata_i[63:0]),
    .sid_i       (s_axis_tdata_i[67:64]),
    .per_i       (s_axis_tdata_i[99:68]),
    .rep_i       (s_axis_tdata_i[100]),
    .rnow_i      (s_axis_tdata_i[101]),
    .utag_i      (s_axis_tdata_i[133:102]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .wr_o        (wr),
    .scan_o      (chain_w[0]),
    .scan_i      (chain_w[NUM_TIMERS])
  );

  // one cell per slot, each handing the record to its neighbor every cycle
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    dtt_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .scan_i (chain_w[i]),
      .scan_o (chain_w[i+1])
    );
  end

  // result register fields packed onto the master side
  assign m_axis_tdata_o = {2'b00, res.any, res.fn, res.wait_ms, res.tag, res.slot};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

  // after a request is taken the block is not ready in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while a previous one was in flight");

  // an error or empty answer carries no slot and no tag
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != dtt_pkg::ST_OK |-> m_axis_tdata_o[35:0] == 36'd0)
    else $error("error result carries slot or tag");

  // a wait time only comes with an ok answer
  a_wait_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[99:36] != 64'd0 |-> m_axis_tuser_o == dtt_pkg::ST_OK)
    else $error("wait time on a non-ok result");

  // a front notify means a timer is armed and the answer is ok
  a_notify_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[100] |->
      m_axis_tdata_o[101] && m_axis_tuser_o == dtt_pkg::ST_OK)
    else $error("front notify without an armed timer");

endmodule
